@@ src/tnl_pkg.sv @@
// ---------------------------------------------------------------------------
// tnl_pkg: shared types and constants for the timeline node lookup
// Field widths, command kinds, result status codes and register indexes.
// ---------------------------------------------------------------------------
package tnl_pkg;

    localparam int INDEX_W     = 10;
    localparam int TIME_W      = 48;
    localparam int WEIGHT_W    = 17;
    localparam int STATUS_W    = 2;
    localparam int COUNT_W     = 11;
    localparam int TOL_W       = 20;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 20;
    localparam int S_TDATA_W   = 64;
    localparam int M_TDATA_W   = 40;

    localparam int NODES_DEFAULT = 1024;
    localparam int WFB_DEFAULT   = 16;
    localparam int QUEUE_DEPTH   = 2;

    // input command flag carried on s_tuser
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // result status carried on m_tuser
    localparam logic [STATUS_W-1:0] ST_QUERY_DONE = 2'd0;
    localparam logic [STATUS_W-1:0] ST_WRITE_ACK  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FEW_NODES  = 2'd2;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_NODE_COUNT     = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TIME_TOLERANCE = 1'd1;

    // what the back end has to do with a queued beat
    typedef enum logic [1:0] {
        KIND_WRITE,   // store the timestamp
        KIND_SKIP,    // index beyond the table: acknowledge only
        KIND_QUERY,   // bracket search and weight
        KIND_FEW      // fewer than two nodes in use
    } kind_t;

    typedef struct packed {
        kind_t               kind;
        logic [INDEX_W-1:0]  node_index;
        logic [TIME_W-1:0]   time_value;
    } cmd_t;

endpackage

@@ src/tnl_ram.sv @@
// ---------------------------------------------------------------------------
// tnl_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ---------------------------------------------------------------------------
module tnl_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ src/tnl_queue.sv @@
// ---------------------------------------------------------------------------
// tnl_queue: short command queue between front and back end
// Holds classified beats so that either side can stall on its own.
// ---------------------------------------------------------------------------
module tnl_queue
    import tnl_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output cmd_t head,
    output logic empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = slot_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

@@ src/tnl_front.sv @@
// ---------------------------------------------------------------------------
// tnl_front: input side of the timeline node lookup
// Holds the configuration registers and classifies each input beat.
// ---------------------------------------------------------------------------
module tnl_front
    import tnl_pkg::*;
#(
    parameter int NODES = NODES_DEFAULT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [CFG_INDEX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]         cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          in_cmd,
    input  logic [INDEX_W-1:0]            in_node_index,
    input  logic [TIME_W-1:0]             in_time_value,
    input  logic                          q_full,
    output logic                          push,
    output cmd_t                          push_cmd,
    output logic [$clog2(NODES+1)-1:0]    node_n,
    output logic [TOL_W-1:0]              tolerance
);

    localparam int CNT_W = $clog2(NODES + 1);

    logic [COUNT_W-1:0] node_count_reg;
    logic [TOL_W-1:0]   tolerance_reg;

    assign cfg_ready = 1'b1;
    assign tolerance = tolerance_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_count_reg <= '0;
            tolerance_reg  <= TOL_W'(1);
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_NODE_COUNT:     node_count_reg <= cfg_data[COUNT_W-1:0];
                REG_TIME_TOLERANCE: tolerance_reg  <= cfg_data[TOL_W-1:0];
            endcase
        end
    end

    // saturate the node count to the table size
    assign node_n = (32'(node_count_reg) > NODES) ? CNT_W'(NODES) : CNT_W'(node_count_reg);

    assign in_ready = !q_full;
    assign push     = in_valid && in_ready;

    always_comb begin
        push_cmd.node_index = in_node_index;
        push_cmd.time_value = in_time_value;
        if (in_cmd == CMD_QUERY) begin
            push_cmd.kind = (node_n < CNT_W'(2)) ? KIND_FEW : KIND_QUERY;
        end else begin
            push_cmd.kind = (32'(in_node_index) < NODES) ? KIND_WRITE : KIND_SKIP;
        end
    end

endmodule

@@ src/tnl_back.sv @@
// ---------------------------------------------------------------------------
// tnl_back: execution side of the timeline node lookup
// Owns the timestamp table, runs edge tests, binary search and serial divide.
// ---------------------------------------------------------------------------
module tnl_back
    import tnl_pkg::*;
#(
    parameter int NODES                = NODES_DEFAULT,
    parameter int WEIGHT_FRACTION_BITS = WFB_DEFAULT
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic [$clog2(NODES+1)-1:0]   node_n,
    input  logic [TOL_W-1:0]             tolerance,
    input  logic                         q_empty,
    input  cmd_t                         head,
    output logic                         pop,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [INDEX_W-1:0]           out_left,
    output logic [INDEX_W-1:0]           out_right,
    output logic [WEIGHT_W-1:0]          out_weight,
    output logic [STATUS_W-1:0]          out_status
);

    localparam int ADDR_W = $clog2(NODES);
    localparam int CNT_W  = $clog2(NODES + 1);
    localparam int WFB    = WEIGHT_FRACTION_BITS;
    localparam int STEP_W = $clog2(WFB + 1);
    localparam logic [WFB:0] ONE = {1'b1, {WFB{1'b0}}};

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIRST,
        S_LAST,
        S_SRCH,
        S_LT,
        S_RT,
        S_DIV
    } state_t;

    state_t              state_reg, state_next;
    logic [TIME_W-1:0]   t_reg, t_next;
    logic [CNT_W-1:0]    lo_reg, lo_next, hi_reg, hi_next;
    logic [ADDR_W-1:0]   mid_reg, mid_next;
    logic [ADDR_W-1:0]   left_reg, left_next, right_reg, right_next;
    logic [TIME_W-1:0]   lt_reg, lt_next;
    logic [TIME_W:0]     rem_reg, rem_next;
    logic [TIME_W-1:0]   den_reg, den_next;
    logic [WFB-1:0]      q_reg, q_next;
    logic [STEP_W-1:0]   step_reg, step_next;

    logic                out_valid_reg, out_valid_next;
    logic [INDEX_W-1:0]  out_left_reg, out_left_next, out_right_reg, out_right_next;
    logic [WEIGHT_W-1:0] out_weight_reg, out_weight_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;

    logic                ram_we;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [TIME_W-1:0]   ram_rdata;

    logic                emit_en;
    logic [INDEX_W-1:0]  emit_left, emit_right;
    logic [WFB:0]        emit_weight;
    logic [STATUS_W-1:0] emit_status;

    logic                out_free;
    logic [CNT_W-1:0]    srch_lo, srch_hi, srch_mid, srch_right;
    logic [TIME_W:0]     rem_sh;
    logic                rem_ge;

    tnl_ram #(
        .WIDTH (TIME_W),
        .DEPTH (NODES)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ADDR_W'(head.node_index)),
        .wdata (head.time_value),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign out_free = !out_valid_reg || out_ready;

    // one search step: narrow the window on the entry just read
    always_comb begin
        srch_lo = lo_reg;
        srch_hi = hi_reg;
        if (ram_rdata <= t_reg) begin
            srch_lo = CNT_W'(mid_reg) + 1'b1;
        end else begin
            srch_hi = CNT_W'(mid_reg);
        end
        srch_mid = srch_lo + ((srch_hi - srch_lo) >> 1);
        priority if (srch_lo < CNT_W'(1)) begin
            srch_right = CNT_W'(1);
        end else if (srch_lo > node_n - 1'b1) begin
            srch_right = node_n - 1'b1;
        end else begin
            srch_right = srch_lo;
        end
    end

    // one restoring divide step
    assign rem_sh = {rem_reg[TIME_W-1:0], 1'b0};
    assign rem_ge = (rem_sh >= {1'b0, den_reg});

    always_comb begin
        state_next  = state_reg;
        t_next      = t_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        mid_next    = mid_reg;
        left_next   = left_reg;
        right_next  = right_reg;
        lt_next     = lt_reg;
        rem_next    = rem_reg;
        den_next    = den_reg;
        q_next      = q_reg;
        step_next   = step_reg;
        pop         = 1'b0;
        ram_we      = 1'b0;
        ram_raddr   = '0;
        emit_en     = 1'b0;
        emit_left   = '0;
        emit_right  = '0;
        emit_weight = '0;
        emit_status = ST_QUERY_DONE;

        unique case (state_reg)
            S_IDLE: begin
                if (!q_empty && out_free) begin
                    pop = 1'b1;
                    unique case (head.kind)
                        KIND_WRITE: begin
                            ram_we      = 1'b1;
                            emit_en     = 1'b1;
                            emit_status = ST_WRITE_ACK;
                        end
                        KIND_SKIP: begin
                            emit_en     = 1'b1;
                            emit_status = ST_WRITE_ACK;
                        end
                        KIND_FEW: begin
                            emit_en     = 1'b1;
                            emit_status = ST_FEW_NODES;
                        end
                        KIND_QUERY: begin
                            t_next     = head.time_value;
                            ram_raddr  = '0;
                            state_next = S_FIRST;
                        end
                    endcase
                end
            end
            S_FIRST: begin
                if ({1'b0, t_reg} <= {1'b0, ram_rdata} + (TIME_W + 1)'(tolerance)) begin
                    emit_en    = 1'b1;
                    emit_right = INDEX_W'(1);
                    state_next = S_IDLE;
                end else begin
                    ram_raddr  = ADDR_W'(node_n - 1'b1);
                    state_next = S_LAST;
                end
            end
            S_LAST: begin
                if ({1'b0, t_reg} + (TIME_W + 1)'(tolerance) >= {1'b0, ram_rdata}) begin
                    emit_en     = 1'b1;
                    emit_left   = INDEX_W'(node_n - CNT_W'(2));
                    emit_right  = INDEX_W'(node_n - 1'b1);
                    emit_weight = ONE;
                    state_next  = S_IDLE;
                end else begin
                    lo_next    = '0;
                    hi_next    = node_n;
                    mid_next   = ADDR_W'(node_n >> 1);
                    ram_raddr  = ADDR_W'(node_n >> 1);
                    state_next = S_SRCH;
                end
            end
            S_SRCH: begin
                lo_next = srch_lo;
                hi_next = srch_hi;
                if (srch_lo < srch_hi) begin
                    mid_next  = ADDR_W'(srch_mid);
                    ram_raddr = ADDR_W'(srch_mid);
                end else begin
                    right_next = ADDR_W'(srch_right);
                    left_next  = ADDR_W'(srch_right - 1'b1);
                    ram_raddr  = ADDR_W'(srch_right - 1'b1);
                    state_next = S_LT;
                end
            end
            S_LT: begin
                lt_next    = ram_rdata;
                ram_raddr  = right_reg;
                state_next = S_RT;
            end
            S_RT: begin
                priority if (t_reg <= lt_reg || ram_rdata <= lt_reg) begin
                    emit_en    = 1'b1;
                    emit_left  = INDEX_W'(left_reg);
                    emit_right = INDEX_W'(right_reg);
                    state_next = S_IDLE;
                end else if (t_reg >= ram_rdata) begin
                    emit_en     = 1'b1;
                    emit_left   = INDEX_W'(left_reg);
                    emit_right  = INDEX_W'(right_reg);
                    emit_weight = ONE;
                    state_next  = S_IDLE;
                end else begin
                    rem_next   = {1'b0, t_reg - lt_reg};
                    den_next   = ram_rdata - lt_reg;
                    q_next     = '0;
                    step_next  = '0;
                    state_next = S_DIV;
                end
            end
            S_DIV: begin
                rem_next  = rem_ge ? rem_sh - {1'b0, den_reg} : rem_sh;
                q_next    = {q_reg[WFB-2:0], rem_ge};
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(WFB - 1)) begin
                    emit_en     = 1'b1;
                    emit_left   = INDEX_W'(left_reg);
                    emit_right  = INDEX_W'(right_reg);
                    emit_weight = {1'b0, q_reg[WFB-2:0], rem_ge};
                    state_next  = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase

        out_valid_next  = out_valid_reg && !out_ready;
        out_left_next   = out_left_reg;
        out_right_next  = out_right_reg;
        out_weight_next = out_weight_reg;
        out_status_next = out_status_reg;
        if (emit_en) begin
            out_valid_next  = 1'b1;
            out_left_next   = emit_left;
            out_right_next  = emit_right;
            out_weight_next = WEIGHT_W'(emit_weight);
            out_status_next = emit_status;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
        t_reg          <= t_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        mid_reg        <= mid_next;
        left_reg       <= left_next;
        right_reg      <= right_next;
        lt_reg         <= lt_next;
        rem_reg        <= rem_next;
        den_reg        <= den_next;
        q_reg          <= q_next;
        step_reg       <= step_next;
        out_left_reg   <= out_left_next;
        out_right_reg  <= out_right_next;
        out_weight_reg <= out_weight_next;
        out_status_reg <= out_status_next;
    end

    assign out_valid  = out_valid_reg;
    assign out_left   = out_left_reg;
    assign out_right  = out_right_reg;
    assign out_weight = out_weight_reg;
    assign out_status = out_status_reg;

    // a new result never lands on a beat that is still waiting
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        emit_en |-> (!out_valid_reg || out_ready))
        else $error("result overwrote a pending beat");

    // search window stays non-empty and inside the table
    a_search_window: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SRCH) |-> (lo_reg < hi_reg && hi_reg <= node_n))
        else $error("search window out of range");

    // divider remainder stays below the divisor
    a_div_remainder: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DIV) |-> (rem_reg < {1'b0, den_reg}))
        else $error("divide remainder not below divisor");

    // a divided weight is always a proper fraction
    a_div_weight: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit_en && state_reg == S_DIV) |-> (emit_weight < ONE))
        else $error("divided weight reached one");

endmodule

@@ src/timeline_node_lookup.sv @@
// ---------------------------------------------------------------------------
// timeline_node_lookup: bracket a query time within a table of node times
//
// Beats enter on the s_ stream: s_tuser is the command (write or query),
// s_tdata carries node_index and time_value. A write stores the timestamp
// and returns status "write acknowledged". A query returns the indexes of
// the two nodes around the time and a Q(WEIGHT_FRACTION_BITS) weight toward
// the right node on the m_ stream, status in m_tuser. The cfg_ channel sets
// node_count (index 0) and time_tolerance (index 1); write it only while
// no beat is in flight.
// A write or a too-few-nodes query is answered straight from the queue head;
// a query is first tested against the first and then the last node, and
// otherwise runs a binary search of at most log2(node_count) + 1 steps,
// one table read per step on the RAM's single read port, followed, unless
// the weight settles at zero or one, by one divide step per weight bit.
// One item is worked on at a time; a two-deep command queue keeps accepting
// beats meanwhile. When the receiver stalls, the result holds in the output
// register, the queue fills and then s_tready drops. Reset empties queue and
// output, sets node_count to 0 and time_tolerance to 1; the table is not
// cleared and must be written before it is queried.
// ---------------------------------------------------------------------------
module timeline_node_lookup
    import tnl_pkg::*;
#(
    parameter int NODES                = NODES_DEFAULT,
    parameter int WEIGHT_FRACTION_BITS = WFB_DEFAULT
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // configuration write channel
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    // input stream
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [S_TDATA_W-1:0]   s_tdata,   // node_index[9:0], time_value[57:10], zero pad
    input  logic                   s_tuser,   // cmd
    // result stream
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [M_TDATA_W-1:0]   m_tdata,   // left node[9:0], right node[19:10],
                                              // weight[36:20], zero pad
    output logic [STATUS_W-1:0]    m_tuser    // status
);

    localparam int CNT_W = $clog2(NODES + 1);

    logic                push, pop, q_full, q_empty;
    cmd_t                push_cmd, head;
    logic [CNT_W-1:0]    node_n;
    logic [TOL_W-1:0]    tolerance;
    logic [INDEX_W-1:0]  out_left, out_right;
    logic [WEIGHT_W-1:0] out_weight;

    // front end: config registers and beat classification
    tnl_front #(
        .NODES (NODES)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .in_cmd        (s_tuser),
        .in_node_index (s_tdata[INDEX_W-1:0]),
        .in_time_value (s_tdata[INDEX_W +: TIME_W]),
        .q_full        (q_full),
        .push          (push),
        .push_cmd      (push_cmd),
        .node_n        (node_n),
        .tolerance     (tolerance)
    );

    // decouple intake from execution
    tnl_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (pop),
        .head     (head),
        .empty    (q_empty)
    );

    // back end: table, search, divide and the output register
    tnl_back #(
        .NODES                (NODES),
        .WEIGHT_FRACTION_BITS (WEIGHT_FRACTION_BITS)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .node_n     (node_n),
        .tolerance  (tolerance),
        .q_empty    (q_empty),
        .head       (head),
        .pop        (pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_left   (out_left),
        .out_right  (out_right),
        .out_weight (out_weight),
        .out_status (m_tuser)
    );

    // pack the result fields, lowest field first
    assign m_tdata = {{(M_TDATA_W - 2 * INDEX_W - WEIGHT_W){1'b0}},
                      out_weight, out_right, out_left};

endmodule

@@ test/testbench.sv @@
// ---------------------------------------------------------------------------
// testbench: self-checking regression for timeline_node_lookup
//
// Streams node writes and time queries into the block and predicts every
// result beat from a private copy of the node table and the two registers.
// A short directed pass covers the few-node, near-first, near-last,
// interior and unsorted cases and the field extremes. Random phases follow:
// each one sets node_count and time_tolerance, refills the table prefix with
// non-decreasing timestamps when asked to or when part of it is unwritten,
// then issues queries aimed at brackets and edges, mixed with order-keeping
// and random writes. Both handshake sides idle at random, and once the
// result side holds off long enough to back up the command queue.
// ---------------------------------------------------------------------------
module testbench;
    import tnl_pkg::*;

    localparam int          TABLE_SIZE = NODES_DEFAULT;
    localparam int          FRAC_BITS  = WFB_DEFAULT;
    localparam logic [63:0] TIME_MAX   = 64'h0000_FFFF_FFFF_FFFF;
    localparam int          HOLD_CYCLES = 300;

    // one predicted result beat
    typedef struct {
        logic [INDEX_W-1:0]  left_node;
        logic [INDEX_W-1:0]  right_node;
        logic [WEIGHT_W-1:0] weight;
        logic [STATUS_W-1:0] status;
    } bracket_t;

    // Holds the node table and registers as the block should see them, and
    // the queue of brackets still owed on the result stream.
    class bracket_ledger;
        logic [TIME_W-1:0] node_times [TABLE_SIZE];
        int unsigned       node_count;
        logic [63:0]       tolerance;
        bracket_t          expected_brackets [$];
        int unsigned       mismatches;

        function new();
            node_count = 0;
            tolerance  = 64'd1;
            mismatches = 0;
            foreach (node_times[i]) node_times[i] = '0;
        endfunction

        function void set_register(logic [CFG_INDEX_W-1:0] index,
                                   logic [CFG_DATA_W-1:0] value);
            if (index == REG_NODE_COUNT)
                node_count = value[COUNT_W-1:0];
            else
                tolerance = {44'd0, value[TOL_W-1:0]};
        endfunction

        // Compute the bracket one beat yields, updating the table on writes.
        function bracket_t predict_bracket(logic cmd, logic [INDEX_W-1:0] idx,
                                           logic [TIME_W-1:0] tv);
            bracket_t    r;
            int unsigned n, lo, hi, mid, left, right;
            logic [63:0] tq, first_t, last_t, lt, rt, rem, den, quo;
            r.left_node  = '0;
            r.right_node = '0;
            r.weight     = '0;
            r.status     = ST_QUERY_DONE;
            tq = {16'd0, tv};
            if (cmd == CMD_WRITE) begin
                if (idx < TABLE_SIZE) node_times[idx] = tv;
                r.status = ST_WRITE_ACK;
                return r;
            end
            // saturate an oversized count to the table
            n = (node_count > TABLE_SIZE) ? TABLE_SIZE : node_count;
            if (n < 2) begin
                r.status = ST_FEW_NODES;
                return r;
            end
            first_t = node_times[0];
            last_t  = node_times[n-1];
            if (tq <= first_t + tolerance) begin
                r.right_node = INDEX_W'(1);
                return r;
            end
            // compare as t + tol so the test never wraps
            if (tq + tolerance >= last_t) begin
                r.left_node  = INDEX_W'(n - 2);
                r.right_node = INDEX_W'(n - 1);
                r.weight     = WEIGHT_W'(64'd1 << FRAC_BITS);
                return r;
            end
            // upper bound: first node strictly later than the query
            lo = 0;
            hi = n;
            while (lo < hi) begin
                mid = lo + ((hi - lo) >> 1);
                if ({16'd0, node_times[mid]} <= tq) lo = mid + 1;
                else hi = mid;
            end
            right = (lo < 1) ? 1 : lo;
            if (right > n - 1) right = n - 1;
            left = right - 1;
            lt = node_times[left];
            rt = node_times[right];
            r.left_node  = INDEX_W'(left);
            r.right_node = INDEX_W'(right);
            if (tq <= lt || rt <= lt) begin
                r.weight = '0;
            end else if (tq >= rt) begin
                r.weight = WEIGHT_W'(64'd1 << FRAC_BITS);
            end else begin
                // restoring divide, one quotient bit per fraction bit
                rem = tq - lt;
                den = rt - lt;
                quo = '0;
                for (int b = 0; b < FRAC_BITS; b++) begin
                    rem = rem << 1;
                    quo = quo << 1;
                    if (rem >= den) begin
                        rem = rem - den;
                        quo = quo | 64'd1;
                    end
                end
                r.weight = quo[WEIGHT_W-1:0];
            end
            return r;
        endfunction

        function void note_item(logic cmd, logic [INDEX_W-1:0] idx,
                                logic [TIME_W-1:0] tv);
            expected_brackets.insert(expected_brackets.size(),
                                     predict_bracket(cmd, idx, tv));
        endfunction

        function void check_result(logic [INDEX_W-1:0] left_node,
                                   logic [INDEX_W-1:0] right_node,
                                   logic [WEIGHT_W-1:0] weight,
                                   logic [STATUS_W-1:0] status);
            bracket_t e;
            if (expected_brackets.size() == 0) begin
                $error("unexpected result beat: left %0d right %0d weight %0d status %0d",
                       left_node, right_node, weight, status);
                mismatches++;
                return;
            end
            e = expected_brackets.pop_front();
            if (left_node !== e.left_node) begin
                $error("left_node: expected %0d, actual %0d", e.left_node, left_node);
                mismatches++;
            end
            if (right_node !== e.right_node) begin
                $error("right_node: expected %0d, actual %0d", e.right_node, right_node);
                mismatches++;
            end
            if (weight !== e.weight) begin
                $error("weight: expected %0d, actual %0d", e.weight, weight);
                mismatches++;
            end
            if (status !== e.status) begin
                $error("status: expected %0d, actual %0d", e.status, status);
                mismatches++;
            end
        endfunction
    endclass

    // Drive every input to a known value from time zero.
    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata   = '0;
    logic                   s_tuser   = CMD_WRITE;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic [STATUS_W-1:0]    m_tuser;

    bracket_ledger ledger;
    bit            node_filled [TABLE_SIZE];   // entries written since reset
    int unsigned   send_idle_pct = 7;
    int unsigned   recv_idle_pct = 78;
    bit            squeeze_request = 1'b0;     // ask the receiver for a long hold-off

    timeline_node_lookup #(
        .NODES                (TABLE_SIZE),
        .WEIGHT_FRACTION_BITS (FRAC_BITS)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Abort a hung run; a correct run ends far earlier.
    initial begin
        #5_000_000;
        $display("timeline_node_lookup regression: fail");
        $finish;
    end

    // Result side: stall at the current rate, or hold off for a long
    // stretch when asked so the command queue backs up into s_tready.
    initial begin
        int unsigned stall_cycles_left;
        stall_cycles_left = 0;
        forever begin
            @(posedge aclk);
            if (squeeze_request) begin
                squeeze_request   = 1'b0;
                stall_cycles_left = HOLD_CYCLES;
            end
            if (stall_cycles_left > 0) begin
                m_tready <= 1'b0;
                stall_cycles_left--;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // Check each result beat as it is taken; values are sampled before the
    // edge updates anything.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            ledger.check_result(m_tdata[INDEX_W-1:0],
                                m_tdata[2*INDEX_W-1:INDEX_W],
                                m_tdata[2*INDEX_W+WEIGHT_W-1:2*INDEX_W],
                                m_tuser);
        end
    end

    function automatic logic [63:0] random_time();
        logic [63:0] x;
        x = {$urandom(), $urandom()};
        return x & TIME_MAX;
    endfunction

    // Gap of random magnitude, from zero (duplicate nodes) up to 2^36 - 1.
    function automatic logic [63:0] random_gap();
        logic [63:0] mask;
        mask = (64'd1 << $urandom_range(0, 36)) - 64'd1;
        return random_time() & mask;
    endfunction

    // Offer one beat, idling first at the sender rate, and hold it until taken.
    task automatic send_beat(input logic cmd, input logic [INDEX_W-1:0] idx,
                             input logic [TIME_W-1:0] tv);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {{(S_TDATA_W-INDEX_W-TIME_W){1'b0}}, tv, idx};
        do @(posedge aclk); while (!s_tready);
        if (cmd == CMD_WRITE) node_filled[idx] = 1'b1;
        ledger.note_item(cmd, idx, tv);
    endtask

    // Drop valid and wait until every owed result is out and the block is quiet.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (ledger.expected_brackets.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_register(input logic [CFG_INDEX_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        ledger.set_register(index, value);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // Write entries 0..eff-1 with non-decreasing timestamps from a random base.
    task automatic fill_table(input int unsigned eff);
        logic [63:0] stamp;
        case ($urandom_range(0, 3))
            0:       stamp = '0;
            1:       stamp = random_time() >> 1;
            2:       stamp = random_time() >> 24;
            default: stamp = random_gap();
        endcase
        for (int unsigned i = 0; i < eff; i++) begin
            if (stamp > TIME_MAX) stamp = TIME_MAX;
            send_beat(CMD_WRITE, INDEX_W'(i), stamp[TIME_W-1:0]);
            stamp = stamp + random_gap();
        end
    endtask

    // Aim a query inside a bracket, on a node, around an edge, or anywhere.
    function automatic logic [TIME_W-1:0] pick_query_time(int unsigned eff,
                                                          logic [63:0] tol);
        int unsigned sel, i;
        logic [63:0] lo_t, hi_t, v;
        sel = $urandom_range(0, 99);
        v = random_time();
        if (sel < 50) begin
            i = $urandom_range(0, eff - 2);
            lo_t = ledger.node_times[i];
            hi_t = ledger.node_times[i+1];
            v = (hi_t > lo_t) ? lo_t + random_time() % (hi_t - lo_t + 1) : lo_t;
        end else if (sel < 65) begin
            v = ledger.node_times[$urandom_range(0, eff - 1)];
        end else if (sel < 82) begin
            lo_t = ledger.node_times[eff-1];
            if ($urandom_range(0, 1)) v = ledger.node_times[0] + tol;
            else v = (lo_t > tol) ? lo_t - tol : 64'd0;
            case ($urandom_range(0, 2))
                0:       if (v > 0) v = v - 1;
                2:       v = v + 1;
                default: ;
            endcase
        end
        if (v > TIME_MAX) v = TIME_MAX;
        return v[TIME_W-1:0];
    endfunction

    // One random beat: mostly queries, some order-keeping writes, some noise.
    task automatic random_item(input int unsigned eff, input logic [63:0] tol);
        int unsigned sel, i;
        logic [63:0] lo_t, hi_t, v;
        sel = $urandom_range(0, 99);
        if (sel < 80) begin
            if (eff >= 2) send_beat(CMD_QUERY, INDEX_W'($urandom()), pick_query_time(eff, tol));
            else send_beat(CMD_QUERY, INDEX_W'($urandom()), TIME_W'(random_time()));
        end else if (sel < 90 && eff >= 2) begin
            // rewrite a node between its neighbors to keep the table sorted
            i = $urandom_range(0, eff - 1);
            lo_t = (i > 0) ? {16'd0, ledger.node_times[i-1]} : 64'd0;
            hi_t = (i < eff - 1) ? {16'd0, ledger.node_times[i+1]}
                                 : ledger.node_times[i] + random_gap();
            if (hi_t < lo_t) begin
                v = lo_t;
                lo_t = hi_t;
                hi_t = v;
            end
            v = lo_t + random_time() % (hi_t - lo_t + 1);
            if (v > TIME_MAX) v = TIME_MAX;
            send_beat(CMD_WRITE, INDEX_W'(i), v[TIME_W-1:0]);
        end else begin
            // random write anywhere: may leave the table unsorted
            v = random_time();
            send_beat(CMD_WRITE, INDEX_W'($urandom()), v[TIME_W-1:0]);
        end
    endtask

    // Set both registers while idle, make sure the used prefix is written,
    // then run random beats.
    task automatic run_phase(input int unsigned count_value, input int unsigned tol_value,
                             input int unsigned items, input bit refill, input bit squeeze);
        int unsigned eff;
        settle();
        write_register(REG_NODE_COUNT, CFG_DATA_W'(count_value));
        write_register(REG_TIME_TOLERANCE, CFG_DATA_W'(tol_value));
        eff = (count_value > TABLE_SIZE) ? TABLE_SIZE : count_value;
        if (eff >= 2) begin
            for (int unsigned i = 0; i < eff; i++)
                if (!node_filled[i]) refill = 1'b1;
        end else begin
            refill = 1'b0;
        end
        if (squeeze) squeeze_request = 1'b1;
        if (refill) fill_table(eff);
        repeat (items) random_item(eff, {32'd0, tol_value});
    endtask

    initial begin
        ledger = new();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // ---- directed part ----
        // Too few nodes straight out of reset (count 0), time extremes.
        send_beat(CMD_QUERY, '0, '0);
        send_beat(CMD_QUERY, '1, TIME_MAX[TIME_W-1:0]);
        // Write at both index extremes with both time extremes.
        send_beat(CMD_WRITE, '1, TIME_MAX[TIME_W-1:0]);
        send_beat(CMD_WRITE, '0, '0);
        // A single node is still too few.
        settle();
        write_register(REG_NODE_COUNT, CFG_DATA_W'(1));
        send_beat(CMD_QUERY, '0, 48'd12345);
        // Two nodes, zero tolerance: below, on and past each edge, interior.
        settle();
        write_register(REG_NODE_COUNT, CFG_DATA_W'(2));
        write_register(REG_TIME_TOLERANCE, CFG_DATA_W'(0));
        send_beat(CMD_WRITE, 10'd0, 48'd100);
        send_beat(CMD_WRITE, 10'd1, 48'd200);
        send_beat(CMD_QUERY, '0, 48'd0);
        send_beat(CMD_QUERY, '0, 48'd100);
        send_beat(CMD_QUERY, '0, 48'd101);
        send_beat(CMD_QUERY, '0, 48'd150);
        send_beat(CMD_QUERY, '0, 48'd199);
        send_beat(CMD_QUERY, '0, 48'd200);
        send_beat(CMD_QUERY, '0, TIME_MAX[TIME_W-1:0]);
        // A tolerance wider than the bracket swallows it whole.
        settle();
        write_register(REG_TIME_TOLERANCE, CFG_DATA_W'(1000000));
        send_beat(CMD_QUERY, '0, 48'd150);
        // Unsorted four-node table.
        settle();
        write_register(REG_NODE_COUNT, CFG_DATA_W'(4));
        write_register(REG_TIME_TOLERANCE, CFG_DATA_W'(0));
        send_beat(CMD_WRITE, 10'd0, 48'd10);
        send_beat(CMD_WRITE, 10'd1, 48'd5000);
        send_beat(CMD_WRITE, 10'd2, 48'd300);
        send_beat(CMD_WRITE, 10'd3, 48'd9000);
        send_beat(CMD_QUERY, '0, 48'd1000);
        send_beat(CMD_QUERY, '0, 48'd4000);
        send_beat(CMD_QUERY, '0, 48'd9000);

        // ---- random part, sender mostly busy, receiver mostly stalled ----
        run_phase($urandom_range(2, 8), 0, 60, 1'b1, 1'b0);
        run_phase($urandom_range(2, 16), 1, 60, 1'b1, 1'b0);
        run_phase($urandom_range(2, 32), $urandom_range(0, 1000000), 60, 1'b1, 1'b0);
        run_phase(1, $urandom_range(0, 1000), 30, 1'b0, 1'b0);
        run_phase($urandom_range(2, 12), 1000000, 60, 1'b1, 1'b0);

        // ---- swap the idle rates ----
        settle();
        send_idle_pct = 78;
        recv_idle_pct = 7;
        run_phase(TABLE_SIZE, 0, 80, 1'b1, 1'b0);
        // Count above the table saturates to the table size.
        run_phase(2047, $urandom_range(0, 50), 60, 1'b0, 1'b0);
        run_phase($urandom_range(2, 64), $urandom_range(0, 1000000), 60, 1'b0, 1'b0);
        run_phase(0, 1, 20, 1'b0, 1'b0);

        // ---- no idling; first phase backs up behind a long receiver hold ----
        settle();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_phase($urandom_range(2, 10), $urandom_range(0, 100), 80, 1'b1, 1'b1);
        run_phase(TABLE_SIZE, 1000000, 60, 1'b0, 1'b0);
        run_phase($urandom_range(2, TABLE_SIZE), $urandom_range(0, 1000000), 80, 1'b0, 1'b0);
        run_phase($urandom_range(2, 20), 0, 80, 1'b1, 1'b0);

        // Drain, then give any stray beat time to show up.
        settle();
        repeat (60) @(posedge aclk);
        if (ledger.mismatches == 0 && ledger.expected_brackets.size() == 0) begin
            $display("timeline_node_lookup regression: pass");
        end else begin
            $display("timeline_node_lookup regression: fail");
        end
        $finish;
    end

endmodule
